/* sv/sld_pkg.sv */
`default_nettype none

package sld_pkg;

    // defaults for the top-level parameters
    localparam int MAX_SYNC_BYTES = 8;
    localparam int LENGTH_BYTES   = 4;

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int SYNC_LEN_W = 4;
    localparam int LEN_W      = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LEN        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN = 2'd2;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] SYNC_PATTERN_RST    = 64'd0;
    localparam logic [SYNC_LEN_W-1:0] SYNC_LEN_RST        = 4'd4;
    localparam logic [LEN_W-1:0]      MAX_PAYLOAD_LEN_RST = 32'd65536;

    // receiver phase codes
    localparam logic [1:0] PH_SEEK   = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;

    // lengths above this cannot take another byte without leaving 32 bits
    localparam logic [LEN_W-1:0] LEN_SHIFT_LIMIT = 32'h00FF_FFFF;

    // configuration bundle from the register file to the receiver core
    typedef struct packed {
        logic [CFG_DATA_W-1:0] sync_pattern;
        logic [SYNC_LEN_W-1:0] sync_len;
        logic [LEN_W-1:0]      max_payload_len;
    } sld_cfg_t;

endpackage

`default_nettype wire

/* sv/sld_cfg_regs.sv */
`default_nettype none

module sld_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sld_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sld_pkg::CFG_DATA_W-1:0]   cfg_data,
    output sld_pkg::sld_cfg_t                     cfg
);

    sld_pkg::sld_cfg_t cfg_reg;
    sld_pkg::sld_cfg_t cfg_next;
    logic              cfg_fire;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // register decode, indexes beyond the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_fire) begin
            unique case (cfg_index)
                sld_pkg::CFG_SYNC_PATTERN: begin
                    cfg_next.sync_pattern = cfg_data;
                end
                sld_pkg::CFG_SYNC_LEN: begin
                    cfg_next.sync_len = cfg_data[sld_pkg::SYNC_LEN_W-1:0];
                end
                sld_pkg::CFG_MAX_PAYLOAD_LEN: begin
                    cfg_next.max_payload_len = cfg_data[sld_pkg::LEN_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_pattern    <= sld_pkg::SYNC_PATTERN_RST;
            cfg_reg.sync_len        <= sld_pkg::SYNC_LEN_RST;
            cfg_reg.max_payload_len <= sld_pkg::MAX_PAYLOAD_LEN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* sv/sld_core.sv */
`default_nettype none

module sld_core #(
    parameter int MAX_SYNC_BYTES = sld_pkg::MAX_SYNC_BYTES,
    parameter int LENGTH_BYTES   = sld_pkg::LENGTH_BYTES
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sld_pkg::sld_cfg_t             cfg,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [sld_pkg::BYTE_W-1:0]    s_rx_byte,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sld_pkg::BYTE_W-1:0]         m_payload_byte,
    output logic                               m_last_of_frame,
    output logic                               m_empty_frame,
    output logic                               m_length_rejected
);

    localparam int WinW  = sld_pkg::BYTE_W * MAX_SYNC_BYTES;
    localparam int ScW   = $clog2(MAX_SYNC_BYTES + 1);
    localparam int LenW  = sld_pkg::LEN_W;
    localparam int SlW   = sld_pkg::SYNC_LEN_W;
    localparam logic [ScW-1:0]  SeekMax  = ScW'(MAX_SYNC_BYTES);
    localparam logic [SlW-1:0]  SyncMax  = SlW'(MAX_SYNC_BYTES);
    localparam logic [LenW-1:0] LenBytes = LenW'(LENGTH_BYTES);

    // receiver state
    logic [1:0]      phase_reg, phase_next;
    logic [WinW-1:0] window_reg, window_next;
    logic [ScW-1:0]  seek_count_reg, seek_count_next;
    logic [LenW-1:0] length_shift_reg, length_shift_next;
    logic [LenW-1:0] bytes_count_reg, bytes_count_next;
    logic [LenW-1:0] frame_length_reg, frame_length_next;

    // result register
    logic                      m_valid_reg, m_valid_next;
    logic [sld_pkg::BYTE_W-1:0] m_byte_reg;
    logic                      m_last_reg;
    logic                      m_empty_reg;
    logic                      m_rej_reg;

    logic                       s_fire;
    logic                       res_valid;
    logic [sld_pkg::BYTE_W-1:0] res_byte;
    logic                       res_last;
    logic                       res_empty;
    logic                       res_rej;

    logic [SlW-1:0]                    eff_len;
    logic [WinW+sld_pkg::BYTE_W-1:0]   window_wide;
    logic [WinW-1:0]                   window_shift;
    logic [ScW-1:0]                    seek_inc;
    logic [MAX_SYNC_BYTES-1:0]         byte_ok;
    logic                              sync_hit;
    logic [LenW-1:0]                   len_shift_inc;
    logic [LenW-1:0]                   cnt_inc;

    // a new beat is taken whenever the result slot is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // effective sync length, clamped to 1..MAX_SYNC_BYTES
    always_comb begin
        priority if (cfg.sync_len == '0) begin
            eff_len = SlW'(1);
        end else if (cfg.sync_len > SyncMax) begin
            eff_len = SyncMax;
        end else begin
            eff_len = cfg.sync_len;
        end
    end

    // window after the new byte and saturating seek count
    assign window_wide  = {window_reg, s_rx_byte};
    assign window_shift = window_wide[WinW-1:0];
    assign seek_inc     = (seek_count_reg == SeekMax) ? seek_count_reg
                                                      : seek_count_reg + ScW'(1);

    // per-byte pattern compare, bytes beyond the sync length always match
    for (genvar k = 0; k < MAX_SYNC_BYTES; k++) begin : g_match
        assign byte_ok[k] = (k >= int'(eff_len)) ||
            (window_shift[k*sld_pkg::BYTE_W +: sld_pkg::BYTE_W] ==
             cfg.sync_pattern[k*sld_pkg::BYTE_W +: sld_pkg::BYTE_W]);
    end
    assign sync_hit = (&byte_ok) && (SlW'(seek_inc) >= eff_len);

    // length assembly with saturation and shared byte counter
    assign len_shift_inc = (length_shift_reg > sld_pkg::LEN_SHIFT_LIMIT) ? '1
                           : {length_shift_reg[LenW-sld_pkg::BYTE_W-1:0], s_rx_byte};
    assign cnt_inc = bytes_count_reg + LenW'(1);

    // per-beat step
    always_comb begin
        phase_next        = phase_reg;
        window_next       = window_reg;
        seek_count_next   = seek_count_reg;
        length_shift_next = length_shift_reg;
        bytes_count_next  = bytes_count_reg;
        frame_length_next = frame_length_reg;
        res_valid         = 1'b0;
        res_byte          = '0;
        res_last          = 1'b0;
        res_empty         = 1'b0;
        res_rej           = 1'b0;
        if (s_fire) begin
            unique case (phase_reg)
                sld_pkg::PH_LENGTH: begin
                    length_shift_next = len_shift_inc;
                    bytes_count_next  = cnt_inc;
                    if (cnt_inc >= LenBytes) begin
                        priority if (len_shift_inc == '0) begin
                            res_valid = 1'b1;
                            res_last  = 1'b1;
                            res_empty = 1'b1;
                            phase_next        = sld_pkg::PH_SEEK;
                            length_shift_next = '0;
                            bytes_count_next  = '0;
                        end else if (len_shift_inc > cfg.max_payload_len) begin
                            res_valid = 1'b1;
                            res_rej   = 1'b1;
                            phase_next        = sld_pkg::PH_SEEK;
                            length_shift_next = '0;
                            bytes_count_next  = '0;
                        end else begin
                            phase_next        = sld_pkg::PH_DATA;
                            frame_length_next = len_shift_inc;
                            bytes_count_next  = '0;
                        end
                    end
                end
                sld_pkg::PH_DATA: begin
                    res_valid = 1'b1;
                    res_byte  = s_rx_byte;
                    if (cnt_inc >= frame_length_reg) begin
                        res_last          = 1'b1;
                        phase_next        = sld_pkg::PH_SEEK;
                        length_shift_next = '0;
                        bytes_count_next  = '0;
                        frame_length_next = '0;
                    end else begin
                        bytes_count_next = cnt_inc;
                    end
                end
                default: begin
                    // seeking, also the unused phase code
                    phase_next      = sld_pkg::PH_SEEK;
                    window_next     = window_shift;
                    seek_count_next = seek_inc;
                    if (sync_hit) begin
                        phase_next        = sld_pkg::PH_LENGTH;
                        window_next       = '0;
                        seek_count_next   = '0;
                        length_shift_next = '0;
                        bytes_count_next  = '0;
                        frame_length_next = '0;
                    end
                end
            endcase
        end
    end

    // result slot holds until taken
    assign m_valid_next = res_valid || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= sld_pkg::PH_SEEK;
            window_reg       <= '0;
            seek_count_reg   <= '0;
            length_shift_reg <= '0;
            bytes_count_reg  <= '0;
            frame_length_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            window_reg       <= window_next;
            seek_count_reg   <= seek_count_next;
            length_shift_reg <= length_shift_next;
            bytes_count_reg  <= bytes_count_next;
            frame_length_reg <= frame_length_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_byte_reg  <= res_byte;
            m_last_reg  <= res_last;
            m_empty_reg <= res_empty;
            m_rej_reg   <= res_rej;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_payload_byte    = m_byte_reg;
    assign m_last_of_frame   = m_last_reg;
    assign m_empty_frame     = m_empty_reg;
    assign m_length_rejected = m_rej_reg;

    // payload counter stays inside a nonzero frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == sld_pkg::PH_DATA) |->
            (frame_length_reg != '0) && (bytes_count_reg < frame_length_reg))
        else $error("payload count outside frame length");

    // length counter stays below the prefix size
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == sld_pkg::PH_LENGTH) |-> (bytes_count_reg < LenBytes))
        else $error("length byte count overrun");

    // seeking keeps the frame counters clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == sld_pkg::PH_SEEK) |->
            (length_shift_reg == '0) && (bytes_count_reg == '0) &&
            (frame_length_reg == '0))
        else $error("frame state not cleared while seeking");

    // a fresh empty or rejected result leaves the receiver seeking
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(s_fire) && m_valid_reg && (m_empty_reg || m_rej_reg))
            |-> (phase_reg == sld_pkg::PH_SEEK))
        else $error("frame ending did not return to seeking");

endmodule

`default_nettype wire

/* sv/sync_length_prefixed_deframer.sv */
// latency: a result appears in the cycle after the beat that causes it
// throughput: one byte per cycle; s_ready drops only while a result waits on m_ready
// the rate is set by the single result register between the byte step and m_*
// reset: synchronous, active low; receiver returns to seeking with a cleared window
// reset also restores sync_pattern 0, sync_len 4 and max_payload_len 65536
`default_nettype none

module sync_length_prefixed_deframer #(
    parameter int MAX_SYNC_BYTES = sld_pkg::MAX_SYNC_BYTES,
    parameter int LENGTH_BYTES   = sld_pkg::LENGTH_BYTES
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sld_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sld_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [sld_pkg::BYTE_W-1:0]       s_rx_byte,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [sld_pkg::BYTE_W-1:0]            m_payload_byte,
    output logic                                  m_last_of_frame,
    output logic                                  m_empty_frame,
    output logic                                  m_length_rejected
);

    sld_pkg::sld_cfg_t cfg;

    // configuration registers
    sld_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sync search, length collection and payload pass-through
    sld_core #(
        .MAX_SYNC_BYTES (MAX_SYNC_BYTES),
        .LENGTH_BYTES   (LENGTH_BYTES)
    ) u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_payload_byte    (m_payload_byte),
        .m_last_of_frame   (m_last_of_frame),
        .m_empty_frame     (m_empty_frame),
        .m_length_rejected (m_length_rejected)
    );

endmodule

`default_nettype wire

/* dv/tb_sync_length_prefixed_deframer.sv */
`timescale 1ns / 1ps

module tb_sync_length_prefixed_deframer;

    localparam int unsigned ITEM_TARGET  = 1350;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES  = 300;

    // index two bits wide, so one code is left without a register
    localparam logic [sld_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [sld_pkg::BYTE_W-1:0] payload_byte;
        logic                       last_of_frame;
        logic                       empty_frame;
        logic                       length_rejected;
    } frame_beat_t;

    // deframer state mirror plus queue of result beats still to arrive
    class deframe_scoreboard;
        logic [sld_pkg::CFG_DATA_W-1:0] sync_pattern;
        logic [sld_pkg::SYNC_LEN_W-1:0] sync_len;
        logic [sld_pkg::LEN_W-1:0]      max_len;
        logic [1:0]                     phase;
        logic [63:0]                    window;
        int unsigned                    seek_count;
        logic [sld_pkg::LEN_W-1:0]      length_shift;
        logic [sld_pkg::LEN_W-1:0]      bytes_count;
        logic [sld_pkg::LEN_W-1:0]      frame_length;
        frame_beat_t                    expected_beats[$];
        int unsigned                    mismatches;
        int unsigned                    beats_checked;
        int unsigned                    frames_closed;
        int unsigned                    empty_seen;
        int unsigned                    rejected_seen;

        function new();
            sync_pattern  = sld_pkg::SYNC_PATTERN_RST;
            sync_len      = sld_pkg::SYNC_LEN_RST;
            max_len       = sld_pkg::MAX_PAYLOAD_LEN_RST;
            mismatches    = 0;
            beats_checked = 0;
            frames_closed = 0;
            empty_seen    = 0;
            rejected_seen = 0;
            return_to_seek();
        endfunction

        function void return_to_seek();
            phase        = sld_pkg::PH_SEEK;
            window       = '0;
            seek_count   = 0;
            length_shift = '0;
            bytes_count  = '0;
            frame_length = '0;
        endfunction

        // sync length as the hardware uses it: zero means one, clipped at the max
        function int unsigned active_sync_len();
            int unsigned n;
            n = 32'(sync_len);
            if (n == 0) n = 1;
            if (n > sld_pkg::MAX_SYNC_BYTES) n = sld_pkg::MAX_SYNC_BYTES;
            return n;
        endfunction

        function void set_reg(input logic [sld_pkg::CFG_IDX_W-1:0] idx,
                              input logic [sld_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                sld_pkg::CFG_SYNC_PATTERN:    sync_pattern = data;
                sld_pkg::CFG_SYNC_LEN:        sync_len = data[sld_pkg::SYNC_LEN_W-1:0];
                sld_pkg::CFG_MAX_PAYLOAD_LEN: max_len = data[sld_pkg::LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // one byte through the deframer; returns 1 when it yields a beat
        function bit deframe_byte(input logic [sld_pkg::BYTE_W-1:0] b,
                                  output frame_beat_t beat);
            int unsigned n;
            logic [63:0] m;
            beat = '0;
            if (phase == sld_pkg::PH_LENGTH) begin
                if (length_shift > sld_pkg::LEN_SHIFT_LIMIT) length_shift = '1;
                else length_shift = {length_shift[sld_pkg::LEN_W-9:0], b};
                bytes_count = bytes_count + 1;
                if (bytes_count >= sld_pkg::LENGTH_BYTES) begin
                    if (length_shift == 0) begin
                        beat.last_of_frame = 1'b1;
                        beat.empty_frame   = 1'b1;
                        return_to_seek();
                        return 1'b1;
                    end
                    if (length_shift > max_len) begin
                        beat.length_rejected = 1'b1;
                        return_to_seek();
                        return 1'b1;
                    end
                    phase        = sld_pkg::PH_DATA;
                    frame_length = length_shift;
                    bytes_count  = '0;
                end
                return 1'b0;
            end
            if (phase == sld_pkg::PH_DATA) begin
                bytes_count       = bytes_count + 1;
                beat.payload_byte = b;
                if (bytes_count >= frame_length) begin
                    beat.last_of_frame = 1'b1;
                    return_to_seek();
                end
                return 1'b1;
            end
            // seeking: shift in and compare the newest bytes against the pattern
            phase  = sld_pkg::PH_SEEK;
            window = {window[55:0], b};
            if (seek_count < sld_pkg::MAX_SYNC_BYTES) seek_count++;
            n = active_sync_len();
            m = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
            if (seek_count >= n && ((window ^ sync_pattern) & m) == 0) begin
                return_to_seek();
                phase = sld_pkg::PH_LENGTH;
            end
            return 1'b0;
        endfunction

        function void note_byte(input logic [sld_pkg::BYTE_W-1:0] b);
            frame_beat_t beat;
            if (deframe_byte(b, beat)) expected_beats.push_back(beat);
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction

        function void compare_field(input string name, input logic [7:0] exp_v,
                                    input logic [7:0] act_v);
            if (exp_v !== act_v) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(input frame_beat_t act);
            frame_beat_t exp_b;
            if (expected_beats.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat, expected none actual %0h", $time, act);
                return;
            end
            exp_b = expected_beats.pop_front();
            beats_checked++;
            if (exp_b.empty_frame) empty_seen++;
            else if (exp_b.length_rejected) rejected_seen++;
            else if (exp_b.last_of_frame) frames_closed++;
            compare_field("payload_byte", exp_b.payload_byte, act.payload_byte);
            compare_field("last_of_frame", 8'(exp_b.last_of_frame),
                          8'(act.last_of_frame));
            compare_field("empty_frame", 8'(exp_b.empty_frame), 8'(act.empty_frame));
            compare_field("length_rejected", 8'(exp_b.length_rejected),
                          8'(act.length_rejected));
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [sld_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sld_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [sld_pkg::BYTE_W-1:0]     s_rx_byte = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [sld_pkg::BYTE_W-1:0]     m_payload_byte;
    logic                           m_last_of_frame;
    logic                           m_empty_frame;
    logic                           m_length_rejected;

    deframe_scoreboard sb = new();

    int unsigned cycles = 0;
    int unsigned items = 0;
    int unsigned settings_used = 0;
    int unsigned burst_left = 0;
    bit          hold_req = 1'b0;
    bit          carry = 1'b0;
    logic [sld_pkg::LEN_W-1:0] carry_len = '0;

    sync_length_prefixed_deframer u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_payload_byte    (m_payload_byte),
        .m_last_of_frame   (m_last_of_frame),
        .m_empty_frame     (m_empty_frame),
        .m_length_rejected (m_length_rejected)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // beat monitors: config writes, accepted bytes, delivered results
    always @(posedge aclk) begin
        frame_beat_t act;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.note_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                act.payload_byte    = m_payload_byte;
                act.last_of_frame   = m_last_of_frame;
                act.empty_frame     = m_empty_frame;
                act.length_rejected = m_length_rejected;
                sb.check_result(act);
            end
        end
    end

    // receiver: random stall mask on m_ready, re-drawn periodically, plus one long hold-off on request
    initial begin : receiver
        int unsigned tick;
        int unsigned hold_left;
        logic [15:0] stall_mask;
        tick = 0;
        hold_left = 0;
        stall_mask = '1;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                if (tick % 64 == 0) begin
                    stall_mask = ($urandom_range(0, 2) == 0) ? '1 : 16'($urandom);
                end
                m_ready = stall_mask[tick % 16];
                tick++;
            end
        end
    end

    // one byte beat, with burst/gap pacing; returns at a falling edge with valid held
    task automatic push_byte(input logic [sld_pkg::BYTE_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid   = 1'b1;
        s_rx_byte = b;
        do @(posedge aclk); while (!s_ready);
        items++;
        @(negedge aclk);
    endtask

    // wait until every expected beat is out and the block is quiet
    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [sld_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sld_pkg::CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // program all three registers; unused upper data bits carry junk
    task automatic apply_setting(input logic [sld_pkg::CFG_DATA_W-1:0] pattern,
                                 input logic [sld_pkg::SYNC_LEN_W-1:0] slen,
                                 input logic [sld_pkg::LEN_W-1:0] maxlen);
        logic [sld_pkg::CFG_DATA_W-1:0] data;
        drain();
        write_cfg(sld_pkg::CFG_SYNC_PATTERN, pattern);
        data = {$urandom, $urandom};
        data[sld_pkg::SYNC_LEN_W-1:0] = slen;
        write_cfg(sld_pkg::CFG_SYNC_LEN, data);
        data = {$urandom, $urandom};
        data[sld_pkg::LEN_W-1:0] = maxlen;
        write_cfg(sld_pkg::CFG_MAX_PAYLOAD_LEN, data);
        if ($urandom_range(0, 3) == 0) write_cfg(CFG_UNUSED, {$urandom, $urandom});
        settings_used++;
    endtask

    task automatic send_sync();
        int unsigned n;
        n = sb.active_sync_len();
        for (int i = n; i > 0; i--) begin
            push_byte(sb.sync_pattern[8*(i-1) +: 8]);
        end
    endtask

    // big-endian length bytes first_b .. last_b-1
    task automatic send_length(input logic [sld_pkg::LEN_W-1:0] len, input int first_b,
                               input int last_b);
        for (int k = first_b; k < last_b; k++) begin
            push_byte(len[8*(sld_pkg::LENGTH_BYTES-1-k) +: 8]);
        end
    endtask

    task automatic send_payload(input logic [sld_pkg::LEN_W-1:0] len);
        if (len != 0 && len <= sb.max_len) begin
            for (int unsigned k = 0; k < len; k++) begin
                push_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // noise never ends on the last pattern byte, so it cannot close a match
    task automatic push_noise(input int unsigned count);
        logic [sld_pkg::BYTE_W-1:0] nb;
        repeat (count) begin
            do nb = 8'($urandom_range(0, 255)); while (nb == sb.sync_pattern[7:0]);
            push_byte(nb);
        end
    endtask

    // complete a length split across a register update
    task automatic finish_carry();
        if (carry) begin
            send_length(carry_len, 2, sld_pkg::LENGTH_BYTES);
            send_payload(carry_len);
            carry = 1'b0;
        end
    endtask

    initial begin : stimulus
        int unsigned phase_goal;
        int unsigned r;
        int unsigned n;
        int unsigned k;
        logic [sld_pkg::CFG_DATA_W-1:0] pattern;
        logic [sld_pkg::SYNC_LEN_W-1:0] slen;
        logic [sld_pkg::LEN_W-1:0] maxlen;
        logic [sld_pkg::LEN_W-1:0] len;
        logic [sld_pkg::SYNC_LEN_W-1:0] slen_edges[5];
        logic [sld_pkg::LEN_W-1:0] max_edges[5];

        slen_edges = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9};
        max_edges  = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd12};

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset-default sync, one-byte frame, empty frame
        send_sync();
        send_length(32'd1, 0, sld_pkg::LENGTH_BYTES);
        push_byte(8'hFF);
        send_sync();
        send_length(32'd0, 0, sld_pkg::LENGTH_BYTES);
        // directed: all-ones one-byte sync, top length rejected, length at the limit
        apply_setting('1, 4'd1, 32'd1);
        send_sync();
        send_length(32'hFFFF_FFFF, 0, sld_pkg::LENGTH_BYTES);
        send_sync();
        send_length(32'd1, 0, sld_pkg::LENGTH_BYTES);
        push_byte(8'h00);

        // random phases, each under its own register setting
        for (int p = 0; items < ITEM_TARGET; p++) begin
            case ($urandom_range(0, 5))
                0: pattern = '0;
                1: pattern = '1;
                default: pattern = {$urandom, $urandom};
            endcase
            if (p < 5) begin
                slen   = slen_edges[p];
                maxlen = max_edges[p];
            end else begin
                slen = 4'($urandom_range(0, 15));
                case ($urandom_range(0, 5))
                    0: maxlen = 32'hFFFF_FFFF;
                    1: maxlen = 32'd0;
                    2: maxlen = $urandom_range(100, 70000);
                    default: maxlen = $urandom_range(1, 24);
                endcase
            end
            apply_setting(pattern, slen, maxlen);
            finish_carry();
            // long receiver hold-off while bytes keep coming
            if (p == 2) hold_req = 1'b1;

            phase_goal = items + $urandom_range(60, 120);
            while (items < phase_goal) begin
                n = sb.active_sync_len();
                r = $urandom_range(0, 9);
                if (r < 2) begin
                    push_noise($urandom_range(1, 4));
                end else if (r == 2 && n > 1) begin
                    // broken start sequence: a proper prefix, then one noise byte
                    k = $urandom_range(1, n - 1);
                    for (int i = n; i > n - k; i--) push_byte(sb.sync_pattern[8*(i-1) +: 8]);
                    push_noise(1);
                end

                r = $urandom_range(0, 99);
                if (r < 8) begin
                    len = '0;
                end else if (r < 16 && sb.max_len != '1) begin
                    len = (r % 2 == 0) ? '1 : sb.max_len + $urandom_range(1, 1000);
                end else if (r < 24 && sb.max_len <= 40) begin
                    len = sb.max_len;
                end else if (r >= 95) begin
                    len = $urandom_range(40, 200);
                end else begin
                    len = $urandom_range(1, 12);
                end
                send_sync();
                send_length(len, 0, sld_pkg::LENGTH_BYTES);
                send_payload(len);
            end

            // sometimes stop halfway through a length so the next setting lands mid-frame
            if ($urandom_range(0, 2) == 0) begin
                carry_len = $urandom_range(0, 40);
                send_sync();
                send_length(carry_len, 0, 2);
                carry = 1'b1;
            end
        end
        finish_carry();

        drain();
        $display("covered %0d input bytes under %0d register settings",
                 items, settings_used + 1);
        $display("checked %0d beats: %0d frames closed, %0d empty, %0d rejected",
                 sb.beats_checked, sb.frames_closed, sb.empty_seen, sb.rejected_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/sld_pkg.sv
sv/sld_cfg_regs.sv
sv/sld_core.sv
sv/sync_length_prefixed_deframer.sv
dv/tb_sync_length_prefixed_deframer.sv
